@@ design/apct_pkg.sv @@
// ----------------------------------------------------------------------------
// apct_pkg
// Shared widths, result codes and controller/datapath link types for the
// box-pair contact tracker.
// ----------------------------------------------------------------------------
package apct_pkg;

    localparam int ID_W           = 32;
    localparam int KEY_W          = 2 * ID_W;
    localparam int POS_W          = 20;
    localparam int SIZE_W         = 19;
    localparam int PAIR_SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_STAY  = 2'd2,
        EV_END   = 2'd3
    } contact_event_t;

    typedef struct packed {
        logic load;
        logic geom;
        logic scan;
        logic commit;
    } apct_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_stall;
    } apct_status_t;

endpackage

@@ design/apct_ctrl.sv @@
// ----------------------------------------------------------------------------
// apct_ctrl
// Sequencer for one item: capture, geometry, table scan, commit of the
// result and of the table update.
// ----------------------------------------------------------------------------
module apct_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  apct_pkg::apct_status_t status,
    output apct_pkg::apct_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEOM,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_GEOM;
                end
            end
            ST_GEOM:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready   = in_ready_reg;
    assign cmd.load   = in_valid && in_ready_reg;
    assign cmd.geom   = (state_reg == ST_GEOM);
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_DECIDE) && !status.out_stall;

endmodule

@@ design/apct_dpath.sv @@
// ----------------------------------------------------------------------------
// apct_dpath
// Item registers, per-axis overlap test, pair table with serial key search,
// fill count and result register.
// ----------------------------------------------------------------------------
module apct_dpath
#(
    parameter int PAIR_SLOTS = apct_pkg::PAIR_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  apct_pkg::apct_cmd_t                 cmd,
    output apct_pkg::apct_status_t              status,
    input  logic [apct_pkg::ID_W-1:0]           left_id,
    input  logic [apct_pkg::ID_W-1:0]           right_id,
    input  logic signed [apct_pkg::POS_W-1:0]   left_x,
    input  logic signed [apct_pkg::POS_W-1:0]   left_y,
    input  logic signed [apct_pkg::POS_W-1:0]   right_x,
    input  logic signed [apct_pkg::POS_W-1:0]   right_y,
    input  logic [apct_pkg::SIZE_W-1:0]         left_w,
    input  logic [apct_pkg::SIZE_W-1:0]         left_h,
    input  logic [apct_pkg::SIZE_W-1:0]         right_w,
    input  logic [apct_pkg::SIZE_W-1:0]         right_h,
    input  logic                                left_dead,
    input  logic                                right_dead,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          contact_event,
    output logic                                table_full
);

    localparam int IW = $clog2(PAIR_SLOTS);
    localparam int CW = $clog2(PAIR_SLOTS + 1);
    localparam int DW = apct_pkg::POS_W + 1;
    localparam int SW = apct_pkg::SIZE_W + 1;
    localparam int KW = apct_pkg::KEY_W;

    logic [KW-1:0]                      key_reg;
    logic signed [apct_pkg::POS_W-1:0]  lx_reg, ly_reg, rx_reg, ry_reg;
    logic [apct_pkg::SIZE_W-1:0]        lw_reg, lh_reg, rw_reg, rh_reg;
    logic                               dead_reg;

    logic [DW-1:0] dx_reg, dy_reg;
    logic [SW-1:0] sw_reg, sh_reg;

    logic [KW:0]   slot_mem [PAIR_SLOTS];
    logic [KW:0]   mem_q_reg;
    logic          q_vld_reg;
    logic [IW-1:0] q_idx_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic [CW-1:0] used_reg;
    logic          found_reg;
    logic [IW-1:0] slot_reg;
    logic          before_reg;

    logic          out_valid_reg;
    logic [1:0]    event_reg;
    logic          full_reg;

    logic signed [DW-1:0] dx_s, dy_s;
    logic          issue;
    logic [IW-1:0] rd_addr;
    logic          match;
    logic          hit;
    logic          is_full;
    logic          prev_over;
    logic [IW-1:0] wr_addr;
    apct_pkg::contact_event_t ev;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= {right_id, left_id};
            lx_reg   <= left_x;
            ly_reg   <= left_y;
            rx_reg   <= right_x;
            ry_reg   <= right_y;
            lw_reg   <= left_w;
            lh_reg   <= left_h;
            rw_reg   <= right_w;
            rh_reg   <= right_h;
            dead_reg <= left_dead | right_dead;
        end
    end

    // Geometry
    assign dx_s = DW'(lx_reg) - DW'(rx_reg);
    assign dy_s = DW'(ly_reg) - DW'(ry_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.geom)
        begin
            dx_reg <= dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
            dy_reg <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
            sw_reg <= SW'(lw_reg) + SW'(rw_reg);
            sh_reg <= SW'(lh_reg) + SW'(rh_reg);
        end
    end

    assign hit = !dead_reg
        && ({dx_reg, 1'b0} < (DW + 1)'(sw_reg))
        && ({dy_reg, 1'b0} < (DW + 1)'(sh_reg));

    // Table search
    assign issue   = cmd.scan && (scan_cnt_reg < used_reg);
    assign rd_addr = scan_cnt_reg[IW-1:0];
    assign match   = q_vld_reg && (mem_q_reg[KW-1:0] == key_reg);

    assign status.scan_done = match || (!issue && !q_vld_reg);
    assign status.out_stall = out_valid_reg && !out_ready;

    // Decision
    assign is_full   = !found_reg && (used_reg == CW'(PAIR_SLOTS));
    assign prev_over = found_reg && before_reg;
    assign wr_addr   = found_reg ? slot_reg : used_reg[IW-1:0];

    always_comb
    begin
        if (hit)
        begin
            ev = prev_over ? apct_pkg::EV_STAY : apct_pkg::EV_BEGIN;
        end
        else
        begin
            ev = prev_over ? apct_pkg::EV_END : apct_pkg::EV_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !is_full)
        begin
            slot_mem[wr_addr] <= {hit, key_reg};
        end
        if (issue)
        begin
            mem_q_reg <= slot_mem[rd_addr];
            q_idx_reg <= rd_addr;
        end
        if (cmd.scan && match)
        begin
            slot_reg   <= q_idx_reg;
            before_reg <= mem_q_reg[KW];
        end
        if (cmd.commit)
        begin
            event_reg <= ev;
            full_reg  <= is_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg     <= 1'b0;
            scan_cnt_reg  <= '0;
            used_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= issue;
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= CW'(scan_cnt_reg + 1'b1);
                end
                if (cmd.scan && match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit && !found_reg && !is_full)
            begin
                used_reg <= CW'(used_reg + 1'b1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign contact_event = event_reg;
    assign table_full    = full_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(PAIR_SLOTS))
        else $error("pair count beyond table size");

    a_full_no_history: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && is_full |-> ev == apct_pkg::EV_NONE || ev == apct_pkg::EV_BEGIN)
        else $error("unstored pair reported a previous overlap");

    a_new_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !found_reg && !is_full |=> used_reg == CW'($past(used_reg) + 1'b1))
        else $error("new pair not counted");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> scan_cnt_reg <= used_reg)
        else $error("search ran past the filled slots");

endmodule

@@ design/aabb_pair_contact_tracker_core.sv @@
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker_core
// Box-pair overlap test with begin/stay/end tracking per ordered id pair.
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, left_*/right_* fields
//   out      source     out_valid, out_ready, contact_event, table_full
//
// An item passes through one geometry step, a search of the filled slots at one
// memory read per cycle with each read registered before the key compare,
// one commit and a return to idle with in_ready high.
// The search length follows the number of stored pairs and stops at a match.
// Reset empties the table through its fill count; no clearing pass.
// A result waits in the output register while the next item is taken in;
// commit holds until that register is free.
// ----------------------------------------------------------------------------
module aabb_pair_contact_tracker_core
#(
    parameter int PAIR_SLOTS = apct_pkg::PAIR_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [apct_pkg::ID_W-1:0]           left_id,
    input  logic [apct_pkg::ID_W-1:0]           right_id,
    input  logic signed [apct_pkg::POS_W-1:0]   left_x,
    input  logic signed [apct_pkg::POS_W-1:0]   left_y,
    input  logic signed [apct_pkg::POS_W-1:0]   right_x,
    input  logic signed [apct_pkg::POS_W-1:0]   right_y,
    input  logic [apct_pkg::SIZE_W-1:0]         left_w,
    input  logic [apct_pkg::SIZE_W-1:0]         left_h,
    input  logic [apct_pkg::SIZE_W-1:0]         right_w,
    input  logic [apct_pkg::SIZE_W-1:0]         right_h,
    input  logic                                left_dead,
    input  logic                                right_dead,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          contact_event,
    output logic                                table_full
);

    apct_pkg::apct_cmd_t    cmd;
    apct_pkg::apct_status_t status;

    apct_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    apct_dpath #(
        .PAIR_SLOTS (PAIR_SLOTS)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .left_id       (left_id),
        .right_id      (right_id),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_x       (right_x),
        .right_y       (right_y),
        .left_w        (left_w),
        .left_h        (left_h),
        .right_w       (right_w),
        .right_h       (right_h),
        .left_dead     (left_dead),
        .right_dead    (right_dead),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .contact_event (contact_event),
        .table_full    (table_full)
    );

endmodule

@@ test/tb_aabb_pair_contact_tracker_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_pair_contact_tracker_core
// Drives candidate box pairs into the contact tracker with random idling on
// both channels and checks every contact event and table-full flag against a
// local model of the ordered pair table and the overlap test.
// ----------------------------------------------------------------------------
module tb_aabb_pair_contact_tracker_core;

    import apct_pkg::*;

    localparam int SLOTS        = PAIR_SLOTS_DEF;
    localparam int POOL         = 48;
    localparam int RANDOM_ITEMS = 480;
    localparam int CALM_ITEMS   = 50;

    typedef struct {
        logic [ID_W-1:0]          lid;
        logic [ID_W-1:0]          rid;
        logic signed [POS_W-1:0]  lx;
        logic signed [POS_W-1:0]  ly;
        logic signed [POS_W-1:0]  rx;
        logic signed [POS_W-1:0]  ry;
        logic [SIZE_W-1:0]        lw;
        logic [SIZE_W-1:0]        lh;
        logic [SIZE_W-1:0]        rw;
        logic [SIZE_W-1:0]        rh;
        logic                     ld;
        logic                     rd;
    } pair_item_t;

    typedef struct {
        contact_event_t ev;
        logic           full;
    } contact_result_t;

    class contact_scoreboard;
        logic [KEY_W-1:0]  slot_key [SLOTS];
        bit                slot_touch [SLOTS];
        int                slots_filled;
        contact_result_t   pending_events [$];
        int                errors;
        int                results;
        int                seen [4];
        int                full_seen;

        function new();
            slots_filled = 0;
            errors       = 0;
            results      = 0;
            full_seen    = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function bit axis_hit(logic signed [POS_W-1:0] c1, logic signed [POS_W-1:0] c2,
                              logic [SIZE_W-1:0] s1, logic [SIZE_W-1:0] s2);
            int d;
            int sum;
            d = int'(c1) - int'(c2);
            if (d < 0)
                d = -d;
            sum = int'(s1) + int'(s2);
            return (2 * d) < sum;
        endfunction

        function void note_pair(pair_item_t it);
            logic [KEY_W-1:0] key;
            bit               hit;
            bit               was;
            int               slot;
            int               i;
            contact_result_t  r;
            key    = {it.rid, it.lid};
            hit    = !(it.ld || it.rd) && axis_hit(it.lx, it.rx, it.lw, it.rw)
                     && axis_hit(it.ly, it.ry, it.lh, it.rh);
            slot   = -1;
            was    = 1'b0;
            r.full = 1'b0;
            for (i = 0; i < slots_filled; i++)
            begin
                if (slot_key[i] == key)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
            begin
                if (slots_filled < SLOTS)
                begin
                    slot             = slots_filled;
                    slot_key[slot]   = key;
                    slot_touch[slot] = 1'b0;
                    slots_filled++;
                end
                else
                    r.full = 1'b1;
            end
            if (slot >= 0)
                was = slot_touch[slot];
            if (hit)
            begin
                r.ev = was ? EV_STAY : EV_BEGIN;
                if (slot >= 0)
                    slot_touch[slot] = 1'b1;
            end
            else if (was)
            begin
                r.ev             = EV_END;
                slot_touch[slot] = 1'b0;
            end
            else
                r.ev = EV_NONE;
            pending_events.push_back(r);
        endfunction

        function void check_event(logic [1:0] ev, logic full);
            contact_result_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected item, event %0d table_full %0b", $time, ev, full);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            results++;
            if (ev !== want.ev)
            begin
                $display("%0t: contact_event expected %0d (%s) actual %0d",
                         $time, want.ev, want.ev.name(), ev);
                errors++;
            end
            else
                seen[ev]++;
            if (full !== want.full)
            begin
                $display("%0t: table_full expected %0b actual %0b", $time, want.full, full);
                errors++;
            end
            else if (full)
                full_seen++;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ID_W-1:0]          left_id;
    logic [ID_W-1:0]          right_id;
    logic signed [POS_W-1:0]  left_x;
    logic signed [POS_W-1:0]  left_y;
    logic signed [POS_W-1:0]  right_x;
    logic signed [POS_W-1:0]  right_y;
    logic [SIZE_W-1:0]        left_w;
    logic [SIZE_W-1:0]        left_h;
    logic [SIZE_W-1:0]        right_w;
    logic [SIZE_W-1:0]        right_h;
    logic                     left_dead;
    logic                     right_dead;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               contact_event;
    logic                     table_full;

    contact_scoreboard sb;
    bit                calm;
    bit                tx_idle_ok;
    int                items_sent;

    aabb_pair_contact_tracker_core #(.PAIR_SLOTS(SLOTS)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_id       (left_id),
        .right_id      (right_id),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_x       (right_x),
        .right_y       (right_y),
        .left_w        (left_w),
        .left_h        (left_h),
        .right_w       (right_w),
        .right_h       (right_h),
        .left_dead     (left_dead),
        .right_dead    (right_dead),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .contact_event (contact_event),
        .table_full    (table_full)
    );

    always #5 clk = ~clk;

    task automatic send_item(input pair_item_t it);
        in_valid   <= 1'b1;
        left_id    <= it.lid;
        right_id   <= it.rid;
        left_x     <= it.lx;
        left_y     <= it.ly;
        right_x    <= it.rx;
        right_y    <= it.ry;
        left_w     <= it.lw;
        left_h     <= it.lh;
        right_w    <= it.rw;
        right_h    <= it.rh;
        left_dead  <= it.ld;
        right_dead <= it.rd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pair(it);
        items_sent++;
        if (!calm && tx_idle_ok && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_box(input logic [ID_W-1:0] lid, input logic [ID_W-1:0] rid,
                            input int lx, input int ly, input int rx, input int ry,
                            input int lw, input int lh, input int rw, input int rh,
                            input bit ld, input bit rd);
        pair_item_t it;
        it.lid = lid;
        it.rid = rid;
        it.lx  = lx[POS_W-1:0];
        it.ly  = ly[POS_W-1:0];
        it.rx  = rx[POS_W-1:0];
        it.ry  = ry[POS_W-1:0];
        it.lw  = lw[SIZE_W-1:0];
        it.lh  = lh[SIZE_W-1:0];
        it.rw  = rw[SIZE_W-1:0];
        it.rh  = rh[SIZE_W-1:0];
        it.ld  = ld;
        it.rd  = rd;
        send_item(it);
    endtask

    // receive side: random stall bursts, steady stretches, none at the end
    initial
    begin : result_sink
        int stall_left;
        int cycles;
        stall_left = 0;
        cycles     = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (out_valid && out_ready)
                sb.check_event(contact_event, table_full);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_ready <= 1'b1;
            end
            else if (!calm && ((cycles / 600) % 3 != 2) && $urandom_range(0, 9) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 11);
            end
        end
    end

    initial
    begin
        #(4_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        pair_item_t        it;
        logic [ID_W-1:0]   pool_l [POOL];
        logic [ID_W-1:0]   pool_r [POOL];
        int                n;
        int                k;
        int                pick;
        int                span;
        int                dx;
        int                dy;
        logic [31:0]       cx;
        logic [31:0]       cy;
        logic [31:0]       v;

        sb         = new();
        calm       = 1'b0;
        tx_idle_ok = 1'b1;
        items_sent = 0;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        left_id    = '0;
        right_id   = '0;
        left_x     = '0;
        left_y     = '0;
        right_x    = '0;
        right_y    = '0;
        left_w     = '0;
        left_h     = '0;
        right_w    = '0;
        right_h    = '0;
        left_dead  = 1'b0;
        right_dead = 1'b0;

        repeat (10) @(posedge clk);
        rst_n     <= 1'b1;
        @(posedge clk);

        // begin, stay, end and none on one pair; dead owners on either side
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 16, 16, 16, 0, 0);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 16, 16, 16, 0, 0);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 16, 16, 16, 1, 0);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 16, 16, 16, 0, 1);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 16, 16, 16, 0, 0);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 4000, 0, 16, 16, 16, 16, 0, 0);
        send_box(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 4000, 0, 16, 16, 16, 16, 0, 0);
        // reversed order is a pair of its own
        send_box(32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0, 0, 16, 16, 16, 16, 0, 0);
        // extreme centres and sizes
        send_box(32'h1, 32'h2, -524288, 0, 524287, 0, 524287, 524287, 524287, 524287, 0, 0);
        send_box(32'h1, 32'h2, 524287, 524287, 524287, 524287,
                 524287, 524287, 524287, 524287, 0, 0);
        // zero sizes on one axis never overlap
        send_box(32'h1, 32'h2, -524288, -524288, -524288, -524288, 0, 50, 0, 50, 0, 0);
        send_box(32'h1, 32'h2, 100, 100, 100, 100, 50, 0, 50, 0, 0, 0);
        // edges just touching versus just overlapping
        send_box(32'h3, 32'h4, 0, 0, 8, 0, 8, 40, 8, 40, 0, 0);
        send_box(32'h3, 32'h4, 0, 0, 8, 0, 8, 40, 9, 40, 0, 0);
        send_box(32'h3, 32'h4, 0, 0, 0, -8, 40, 9, 40, 8, 0, 0);
        send_box(32'h3, 32'h4, 0, 0, 0, -8, 40, 8, 40, 8, 0, 0);
        send_box(32'h5, 32'h5, 10, 10, 10, 10, 99, 99, 99, 99, 1, 1);
        send_box(32'hAAAA_AAAA, 32'h5555_5555, -300000, 200000, 300000, -200000,
                 524287, 524287, 524287, 524287, 0, 0);
        send_box(32'hAAAA_AAAA, 32'h5555_5555, -300000, 200000, 300000, -200000,
                 524287, 524287, 524287, 524287, 0, 0);

        for (k = 0; k < POOL; k++)
        begin
            pool_l[k] = $urandom();
            pool_r[k] = $urandom();
        end
        it.lid = pool_l[0];
        it.rid = pool_r[0];

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            calm       = (n >= RANDOM_ITEMS - CALM_ITEMS);
            tx_idle_ok = ((n / 40) % 3 != 2);
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL - 1);
            if (pick < 65)
            begin
                it.lid = pool_l[k];
                it.rid = pool_r[k];
            end
            else if (pick < 75)
            begin
                it.lid = pool_r[k];
                it.rid = pool_l[k];
            end
            else if (pick < 85)
            begin
                it.lid = $urandom();
                it.rid = $urandom();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                v = $urandom(); it.lx = v[POS_W-1:0];
                v = $urandom(); it.ly = v[POS_W-1:0];
                v = $urandom(); it.rx = v[POS_W-1:0];
                v = $urandom(); it.ry = v[POS_W-1:0];
                v = $urandom(); it.lw = v[SIZE_W-1:0];
                v = $urandom(); it.lh = v[SIZE_W-1:0];
                v = $urandom(); it.rw = v[SIZE_W-1:0];
                v = $urandom(); it.rh = v[SIZE_W-1:0];
            end
            else
            begin
                span = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 262143)
                                                    : $urandom_range(0, 4096);
                cx = $urandom();
                cy = $urandom();
                dx = $urandom_range(0, 2 * span);
                dy = $urandom_range(0, 2 * span);
                dx = dx - span;
                dy = dy - span;
                it.lx = cx[POS_W-1:0];
                it.ly = cy[POS_W-1:0];
                v = cx + dx; it.rx = v[POS_W-1:0];
                v = cy + dy; it.ry = v[POS_W-1:0];
                v = $urandom_range(0, span); it.lw = v[SIZE_W-1:0];
                v = $urandom_range(0, span); it.lh = v[SIZE_W-1:0];
                v = $urandom_range(0, span); it.rw = v[SIZE_W-1:0];
                v = $urandom_range(0, span); it.rh = v[SIZE_W-1:0];
            end
            it.ld = ($urandom_range(0, 15) == 0);
            it.rd = ($urandom_range(0, 15) == 0);
            send_item(it);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SLOTS + 20) @(posedge clk);
        sb.errors += sb.pending();

        $display("%0d pairs sent, %0d results: begin %0d, stay %0d, end %0d, none %0d",
                 items_sent, sb.results, sb.seen[EV_BEGIN], sb.seen[EV_STAY],
                 sb.seen[EV_END], sb.seen[EV_NONE]);
        $display("table filled to %0d of %0d slots, %0d pairs refused as full",
                 sb.slots_filled, SLOTS, sb.full_seen);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
design/apct_pkg.sv
design/apct_ctrl.sv
design/apct_dpath.sv
design/aabb_pair_contact_tracker_core.sv
test/tb_aabb_pair_contact_tracker_core.sv
